// File: hw/rtl/ptzf_pkg.sv
// Shared types, constants and helpers of the pan/tilt/zoom command framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptzf_pkg;

  // register map, index = byte address / 4
  localparam logic [2:0] REG_PAN_LO  = 3'd0;
  localparam logic [2:0] REG_PAN_HI  = 3'd1;
  localparam logic [2:0] REG_TILT_LO = 3'd2;
  localparam logic [2:0] REG_TILT_HI = 3'd3;
  localparam logic [2:0] REG_ZOOM_LIM = 3'd4;
  localparam logic [2:0] REG_PAN_DB  = 3'd5;
  localparam logic [2:0] REG_TILT_DB = 3'd6;
  localparam logic [2:0] REG_ZOOM_DB = 3'd7;

  // frame bytes
  localparam logic [7:0] FRM_SYNC = 8'hFF;
  localparam logic [7:0] FRM_ADDR = 8'h30;
  localparam logic [7:0] FRM_RSV  = 8'h00;
  localparam logic [7:0] OP_PT    = 8'h62;
  localparam logic [7:0] OP_ZM    = 8'hB3;
  localparam logic [7:0] FRM_END  = 8'hEF;

  // floor(deg*80/9): bias by a multiple of 9 so the dividend is positive,
  // then multiply by a rounded-up reciprocal of 9
  localparam int ANG_OFS_Q = 18205;
  localparam int ANG_OFS   = 9 * ANG_OFS_Q;
  localparam int RECIP_SH  = 23;
  localparam int RECIP_M   = (2 ** RECIP_SH + 8) / 9;
  localparam int CODE_BIAS = 32768 - ANG_OFS_Q;

  // descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [11:0] pan_lo;
    logic signed [11:0] pan_hi;
    logic signed [11:0] tilt_lo;
    logic signed [11:0] tilt_hi;
    logic [15:0]        zoom_lim;
    logic [7:0]         pan_db;
    logic [7:0]         tilt_db;
    logic [7:0]         zoom_db;
  } ptzf_cfg_t;

  typedef struct packed {
    logic        pt;
    logic        zm;
    logic [15:0] pan_code;
    logic [15:0] tilt_code;
    logic [15:0] zoom;
  } ptzf_desc_t;

  typedef struct packed {
    logic              not_empty;
    logic [QLVL_W-1:0] level;
  } ptzf_qstat_t;

  function automatic logic [12:0] abs13(input logic signed [12:0] x);
    abs13 = x[12] ? 13'(-x) : 13'(x);
  endfunction

  function automatic logic [17:0] abs18(input logic signed [17:0] x);
    abs18 = x[17] ? 18'(-x) : 18'(x);
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    hex_ascii = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ptz_command_framer.sv
// Pan/tilt/zoom command framer, top level: config registers, front, queue, back.
// The first frame byte of a command passes the front pipeline registers, the queue entry and the output register.
// Throughput: one byte per cycle while out_tready is high; a command makes 0, 10, 14 or
// 24 bytes, and up to 4 commands are held in flight by the descriptor queue.
// Reset (rst_n low, synchronous): positions zero, limits and dead bands at
// their defaults, queue and output empty.
`default_nettype none

module ptz_command_framer
  import ptzf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pan_cmd[11:0], tilt_cmd[23:12], zoom_cmd[40:24], zeros
  input  wire logic [0:0]  in_tuser,   // relative_mode[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte[7:0]
  output logic [0:0]       out_tuser,  // frame_end[0]
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  ptzf_cfg_t   cfg_r;
  ptzf_desc_t  q_desc, q_head;
  ptzf_qstat_t qstat;
  logic        q_wr, q_pop;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_lo   <= -12'sd98;
      cfg_r.pan_hi   <= 12'sd98;
      cfg_r.tilt_lo  <= -12'sd30;
      cfg_r.tilt_hi  <= 12'sd88;
      cfg_r.zoom_lim <= 16'd1960;
      cfg_r.pan_db   <= 8'd1;
      cfg_r.tilt_db  <= 8'd1;
      cfg_r.zoom_db  <= 8'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAN_LO:   cfg_r.pan_lo   <= cfg_pwdata[11:0];
        REG_PAN_HI:   cfg_r.pan_hi   <= cfg_pwdata[11:0];
        REG_TILT_LO:  cfg_r.tilt_lo  <= cfg_pwdata[11:0];
        REG_TILT_HI:  cfg_r.tilt_hi  <= cfg_pwdata[11:0];
        REG_ZOOM_LIM: cfg_r.zoom_lim <= cfg_pwdata[15:0];
        REG_PAN_DB:   cfg_r.pan_db   <= cfg_pwdata[7:0];
        REG_TILT_DB:  cfg_r.tilt_db  <= cfg_pwdata[7:0];
        REG_ZOOM_DB:  cfg_r.zoom_db  <= cfg_pwdata[7:0];
        default:      cfg_r.zoom_db  <= cfg_r.zoom_db;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAN_LO:   cfg_prdata = {20'd0, cfg_r.pan_lo};
      REG_PAN_HI:   cfg_prdata = {20'd0, cfg_r.pan_hi};
      REG_TILT_LO:  cfg_prdata = {20'd0, cfg_r.tilt_lo};
      REG_TILT_HI:  cfg_prdata = {20'd0, cfg_r.tilt_hi};
      REG_ZOOM_LIM: cfg_prdata = {16'd0, cfg_r.zoom_lim};
      REG_PAN_DB:   cfg_prdata = {24'd0, cfg_r.pan_db};
      REG_TILT_DB:  cfg_prdata = {24'd0, cfg_r.tilt_db};
      default:      cfg_prdata = {24'd0, cfg_r.zoom_db};
    endcase
  end

  ptzf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .pan_cmd       ($signed(in_tdata[11:0])),
    .tilt_cmd      ($signed(in_tdata[23:12])),
    .zoom_cmd      ($signed(in_tdata[40:24])),
    .relative_mode (in_tuser[0]),
    .qstat         (qstat),
    .q_wr          (q_wr),
    .q_desc        (q_desc)
  );

  ptzf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_desc (q_desc),
    .rd      (q_pop),
    .head    (q_head),
    .stat    (qstat)
  );

  ptzf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .qstat       (qstat),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .tx_byte     (out_tdata),
    .frame_end   (out_tuser[0]),
    .last_of_run (out_tlast)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ptzf_front.sv
// Front end: accepts commands, applies dead band and limits, keeps the
// stored position and turns angles into codes. Uses ptzf_pkg.
`default_nettype none

module ptzf_front
  import ptzf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptzf_cfg_t          cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [11:0] pan_cmd,
  input  wire logic signed [11:0] tilt_cmd,
  input  wire logic signed [16:0] zoom_cmd,
  input  wire logic               relative_mode,
  input  wire ptzf_qstat_t        qstat,
  output logic                    q_wr,
  output ptzf_desc_t              q_desc
);

  logic signed [11:0] pan_pos_r, tilt_pos_r;
  logic [15:0]        zoom_pos_r;

  logic va_r, vb_r;
  logic pta_r, zma_r, ptb_r, zmb_r;
  logic signed [11:0] pana_r, tilta_r;
  logic [15:0]        zooma_r, zoomb_r;
  logic [38:0]        pan_prod_r, tilt_prod_r;

  logic in_fire;
  logic [QLVL_W:0] pending;

  logic signed [12:0] pc13, tc13, pp13, tp13;
  logic signed [12:0] pan_cand, tilt_cand, pan_sel, tilt_sel;
  logic signed [12:0] pan_lo13, pan_hi13, tilt_lo13, tilt_hi13;
  logic [12:0]        pan_mag, tilt_mag;
  logic signed [17:0] zc18, zp18, zoom_cand, zoom_sel;
  logic [17:0]        zoom_mag;
  logic pan_chg, tilt_chg, pt, zm;
  logic signed [12:0] pan_clamp, tilt_clamp;
  logic [15:0]        zoom_clamp;

  logic signed [19:0] pan_u, tilt_u;

  // every in-flight item reserves a queue slot so the pipeline never stalls
  assign pending  = (QLVL_W + 1)'(qstat.level) + (QLVL_W + 1)'(va_r) + (QLVL_W + 1)'(vb_r);
  assign in_ready = pending < (QLVL_W + 1)'(QDEPTH);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    pc13 = {pan_cmd[11], pan_cmd};
    tc13 = {tilt_cmd[11], tilt_cmd};
    pp13 = {pan_pos_r[11], pan_pos_r};
    tp13 = {tilt_pos_r[11], tilt_pos_r};
    zc18 = {zoom_cmd[16], zoom_cmd};
    zp18 = {2'b00, zoom_pos_r};

    if (relative_mode) begin
      pan_mag   = abs13(pc13);
      tilt_mag  = abs13(tc13);
      zoom_mag  = abs18(zc18);
      pan_cand  = pc13 + pp13;
      tilt_cand = tc13 + tp13;
      zoom_cand = zc18 + zp18;
    end else begin
      pan_mag   = abs13(pc13 - pp13);
      tilt_mag  = abs13(tc13 - tp13);
      zoom_mag  = abs18(zc18 - zp18);
      pan_cand  = pc13;
      tilt_cand = tc13;
      zoom_cand = zc18;
    end

    pan_chg  = pan_mag > {5'd0, cfg.pan_db};
    tilt_chg = tilt_mag > {5'd0, cfg.tilt_db};
    zm       = zoom_mag > {10'd0, cfg.zoom_db};
    pt       = pan_chg || tilt_chg;

    pan_sel  = pan_chg ? pan_cand : pp13;
    tilt_sel = tilt_chg ? tilt_cand : tp13;
    zoom_sel = zm ? zoom_cand : zp18;

    pan_lo13  = {cfg.pan_lo[11], cfg.pan_lo};
    pan_hi13  = {cfg.pan_hi[11], cfg.pan_hi};
    tilt_lo13 = {cfg.tilt_lo[11], cfg.tilt_lo};
    tilt_hi13 = {cfg.tilt_hi[11], cfg.tilt_hi};

    // pan tests low first, tilt tests high first; matters when limits cross
    priority if (pan_sel < pan_lo13) pan_clamp = pan_lo13;
    else if (pan_sel > pan_hi13)     pan_clamp = pan_hi13;
    else                             pan_clamp = pan_sel;

    priority if (tilt_sel > tilt_hi13) tilt_clamp = tilt_hi13;
    else if (tilt_sel < tilt_lo13)     tilt_clamp = tilt_lo13;
    else                               tilt_clamp = tilt_sel;

    priority if (zoom_sel[17])                  zoom_clamp = 16'd0;
    else if (zoom_sel > {2'b00, cfg.zoom_lim})  zoom_clamp = cfg.zoom_lim;
    else                                        zoom_clamp = zoom_sel[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      pan_pos_r  <= '0;
      tilt_pos_r <= '0;
      zoom_pos_r <= '0;
    end else begin
      va_r <= in_fire;
      vb_r <= va_r;
      if (in_fire && pt) begin
        pan_pos_r  <= pan_clamp[11:0];
        tilt_pos_r <= tilt_clamp[11:0];
      end
      if (in_fire && zm) begin
        zoom_pos_r <= zoom_clamp;
      end
    end
  end

  always_comb begin
    pan_u  = $signed({{8{pana_r[11]}}, pana_r}) * 20'sd80 + 20'(ANG_OFS);
    tilt_u = $signed({{8{tilta_r[11]}}, tilta_r}) * 20'sd80 + 20'(ANG_OFS);
  end

  always_ff @(posedge clk) begin
    pta_r   <= pt;
    zma_r   <= zm;
    pana_r  <= pan_clamp[11:0];
    tilta_r <= tilt_clamp[11:0];
    zooma_r <= zoom_clamp;

    ptb_r       <= pta_r;
    zmb_r       <= zma_r;
    zoomb_r     <= zooma_r;
    pan_prod_r  <= 39'(pan_u[18:0]) * 39'(RECIP_M);
    tilt_prod_r <= 39'(tilt_u[18:0]) * 39'(RECIP_M);
  end

  assign q_wr = vb_r && (ptb_r || zmb_r);

  always_comb begin
    q_desc.pt        = ptb_r;
    q_desc.zm        = zmb_r;
    q_desc.pan_code  = pan_prod_r[RECIP_SH +: 16] + 16'(CODE_BIAS);
    q_desc.tilt_code = tilt_prod_r[RECIP_SH +: 16] + 16'(CODE_BIAS);
    q_desc.zoom      = zoomb_r;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptzf_queue.sv
// Short descriptor queue between the framer front and back ends.
// Uses ptzf_pkg for the descriptor type and depth.
`default_nettype none

module ptzf_queue
  import ptzf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr,
  input  wire ptzf_desc_t  wr_desc,
  input  wire logic        rd,
  output ptzf_desc_t       head,
  output ptzf_qstat_t      stat
);

  ptzf_desc_t        entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({wr, rd})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry_r[wr_ptr_r] <= wr_desc;
  end

  assign head           = entry_r[rd_ptr_r];
  assign stat.level     = level_r;
  assign stat.not_empty = level_r != '0;

endmodule

`default_nettype wire

// File: hw/rtl/ptzf_back.sv
// Back end: walks a queued descriptor byte by byte into the output register.
// Uses ptzf_pkg for frame constants and the descriptor type.
`default_nettype none

module ptzf_back
  import ptzf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ptzf_desc_t  head,
  input  wire ptzf_qstat_t qstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             frame_end,
  output logic             last_of_run
);

  localparam logic [3:0] POS_OP     = 4'd4;
  localparam logic [3:0] POS_W0_END = 4'd8;
  localparam logic [3:0] POS_ZM_END = 4'd9;
  localparam logic [3:0] POS_W1_END = 4'd12;
  localparam logic [3:0] POS_PT_END = 4'd13;

  logic       phase_r;   // 1: zoom frame of the current descriptor
  logic [3:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r, last_r;

  logic       load, zoom_frame, is_end, is_last;
  logic [3:0] end_pos;
  logic [15:0] word0;
  logic [7:0] byte_nxt;

  assign load       = qstat.not_empty && (!valid_r || out_ready);
  assign zoom_frame = phase_r || !head.pt;
  assign end_pos    = zoom_frame ? POS_ZM_END : POS_PT_END;
  assign word0      = zoom_frame ? head.zoom : head.pan_code;
  assign is_end     = idx_r == end_pos;
  assign is_last    = is_end && (zoom_frame || !head.zm);
  assign pop        = load && is_last;

  always_comb begin
    priority if (idx_r < POS_OP) begin
      unique case (idx_r[1:0])
        2'd0:    byte_nxt = FRM_SYNC;
        2'd1:    byte_nxt = FRM_ADDR;
        2'd2:    byte_nxt = FRM_ADDR;
        default: byte_nxt = FRM_RSV;
      endcase
    end else if (idx_r == POS_OP) begin
      byte_nxt = zoom_frame ? OP_ZM : OP_PT;
    end else if (idx_r <= POS_W0_END) begin
      byte_nxt = hex_ascii(word0[2'(POS_W0_END - idx_r) * 4 +: 4]);
    end else if (!is_end) begin
      byte_nxt = hex_ascii(head.tilt_code[2'(POS_W1_END - idx_r) * 4 +: 4]);
    end else begin
      byte_nxt = FRM_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        if (is_last) begin
          phase_r <= 1'b0;
          idx_r   <= '0;
        end else if (is_end) begin
          phase_r <= 1'b1;
          idx_r   <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      end_r  <= is_end;
      last_r <= is_last;
    end
  end

  assign out_valid   = valid_r;
  assign tx_byte     = byte_r;
  assign frame_end   = end_r;
  assign last_of_run = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/ptzf_checker.sv
// Port-level checks of the pan/tilt/zoom command framer, bound to the top.
// Depends only on the top level's port names.
`default_nettype none

module ptzf_port_props (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser,
  input wire logic       out_tlast
);

  // stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output byte changed while stalled");

  // frame_end is set only on footer bytes
  a_footer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'hEF)
    else $error("frame_end on a non-footer byte");

  // a run always ends on a frame footer
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("last_of_run outside a footer");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind ptz_command_framer ptzf_port_props u_chk (.*);

`default_nettype wire

// File: bench/ptzf_checker.sv
// Scoreboard for ptz_command_framer: tracks register writes, predicts the frame
// bytes of every accepted request and compares them with the output stream.
// Depends on ptzf_pkg for register indexes and frame byte constants.
module ptzf_checker
  import ptzf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic [0:0]  out_tuser,
  input  wire logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  // shadow registers
  logic signed [11:0] pan_lo, pan_hi, tilt_lo, tilt_hi;
  logic [15:0]        zoom_lim;
  logic [7:0]         pan_db, tilt_db, zoom_db;

  // stored positions
  logic signed [11:0] pan_pos, tilt_pos;
  logic [15:0]        zoom_pos;

  int nfail = 0;

  function automatic int mag(input int x);
    return (x < 0) ? -x : x;
  endfunction

  // floor(deg * 80 / 9) biased by 0x8000
  function automatic logic [15:0] angle_word(input int deg);
    int n, q;
    n = deg * 80;
    q = n / 9;
    if (n < 0 && q * 9 != n) q = q - 1;
    return 16'(q + 32768);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic fe);
    frame_byte_t fb;
    fb.data = b;
    fb.frame_end = fe;
    fb.last = 1'b0;
    expected_bytes.push_back(fb);
  endfunction

  function automatic void push_head(input logic [7:0] opcode);
    push_byte(FRM_SYNC, 1'b0);
    push_byte(FRM_ADDR, 1'b0);
    push_byte(FRM_ADDR, 1'b0);
    push_byte(FRM_RSV, 1'b0);
    push_byte(opcode, 1'b0);
  endfunction

  function automatic void push_hex4(input logic [15:0] w);
    push_byte(hex_char(w[15:12]), 1'b0);
    push_byte(hex_char(w[11:8]), 1'b0);
    push_byte(hex_char(w[7:4]), 1'b0);
    push_byte(hex_char(w[3:0]), 1'b0);
  endfunction

  task automatic build_frames(input logic [47:0] data, input logic rel);
    int pc, tc, zc, pan, tilt, zoom, before_cnt;
    bit pt_chg, zm_chg;
    frame_byte_t tail;
    pc = int'($signed(data[11:0]));
    tc = int'($signed(data[23:12]));
    zc = int'($signed(data[40:24]));
    pan = int'(pan_pos);
    tilt = int'(tilt_pos);
    zoom = int'(zoom_pos);
    pt_chg = 1'b0;
    zm_chg = 1'b0;
    before_cnt = expected_bytes.size();

    // sums kept at full int width so relative moves never wrap
    if (rel) begin
      if (mag(pc) > int'(pan_db)) begin pan = pc + int'(pan_pos); pt_chg = 1'b1; end
      if (mag(tc) > int'(tilt_db)) begin tilt = tc + int'(tilt_pos); pt_chg = 1'b1; end
      if (mag(zc) > int'(zoom_db)) begin zoom = zc + int'(zoom_pos); zm_chg = 1'b1; end
    end else begin
      if (mag(pc - int'(pan_pos)) > int'(pan_db)) begin pan = pc; pt_chg = 1'b1; end
      if (mag(tc - int'(tilt_pos)) > int'(tilt_db)) begin tilt = tc; pt_chg = 1'b1; end
      if (mag(zc - int'(zoom_pos)) > int'(zoom_db)) begin zoom = zc; zm_chg = 1'b1; end
    end

    if (pt_chg) begin
      // pan tests low first, tilt tests high first: matters with crossed limits
      if (pan < int'(pan_lo)) pan = int'(pan_lo);
      else if (pan > int'(pan_hi)) pan = int'(pan_hi);
      if (tilt > int'(tilt_hi)) tilt = int'(tilt_hi);
      else if (tilt < int'(tilt_lo)) tilt = int'(tilt_lo);
      pan_pos = 12'(pan);
      tilt_pos = 12'(tilt);
      push_head(OP_PT);
      push_hex4(angle_word(pan));
      push_hex4(angle_word(tilt));
      push_byte(FRM_END, 1'b1);
    end
    if (zm_chg) begin
      if (zoom < 0) zoom = 0;
      else if (zoom > int'(zoom_lim)) zoom = int'(zoom_lim);
      zoom_pos = 16'(zoom);
      push_head(OP_ZM);
      push_hex4(16'(zoom));
      push_byte(FRM_END, 1'b1);
    end
    if (expected_bytes.size() > before_cnt) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  task automatic flag(input string msg);
    nfail++;
    if (nfail <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (!rst_n) begin
      pan_lo = 12'(-98);
      pan_hi = 12'd98;
      tilt_lo = 12'(-30);
      tilt_hi = 12'd88;
      zoom_lim = 16'd1960;
      pan_db = 8'd1;
      tilt_db = 8'd1;
      zoom_db = 8'd1;
      pan_pos = '0;
      tilt_pos = '0;
      zoom_pos = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_PAN_LO:   pan_lo = cfg_pwdata[11:0];
          REG_PAN_HI:   pan_hi = cfg_pwdata[11:0];
          REG_TILT_LO:  tilt_lo = cfg_pwdata[11:0];
          REG_TILT_HI:  tilt_hi = cfg_pwdata[11:0];
          REG_ZOOM_LIM: zoom_lim = cfg_pwdata[15:0];
          REG_PAN_DB:   pan_db = cfg_pwdata[7:0];
          REG_TILT_DB:  tilt_db = cfg_pwdata[7:0];
          REG_ZOOM_DB:  zoom_db = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          flag($sformatf("unexpected byte %02h end %0b last %0b",
                         out_tdata, out_tuser[0], out_tlast));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (exp_b !== {out_tdata, out_tuser[0], out_tlast})
            flag($sformatf("byte mismatch: expected %02h end %0b last %0b, got %02h end %0b last %0b",
                           exp_b.data, exp_b.frame_end, exp_b.last,
                           out_tdata, out_tuser[0], out_tlast));
        end
      end
      if (in_tvalid && in_tready) build_frames(in_tdata, in_tuser[0]);
    end
    mismatches <= nfail;
    outstanding <= expected_bytes.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the ptz_command_framer bench: clock, reset, register writes, command
// stimulus with bursty input and stalling output, and the final verdict.
// Depends on ptzf_pkg, the block itself and ptzf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptzf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // pan_cmd[11:0], tilt_cmd[23:12], zoom_cmd[40:24], zeros
  logic [0:0]  in_tuser = '0;   // relative_mode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // tx_byte[7:0]
  logic [0:0]  out_tuser;       // frame_end[0]
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int outstanding;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ptz_command_framer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ptzf_checker frame_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // output backpressure: free-running, switches mode every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_left <= int'($urandom_range(10, 120));
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_left[2:0] != 3'd0);
    endcase
  end

  function automatic int pick_angle();
    case ($urandom_range(0, 5))
      0, 1: return int'($urandom_range(0, 400)) - 200;
      2: return int'($urandom_range(0, 6)) - 3;
      3: return $urandom_range(0, 1) ? 2047 : -2048;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  function automatic int pick_zoom();
    case ($urandom_range(0, 5))
      0, 1: return int'($urandom_range(0, 3000));
      2: return int'($urandom_range(0, 8)) - 4;
      3: return $urandom_range(0, 1) ? 65535 : -65536;
      4: return -int'($urandom_range(1, 3000));
      default: return int'($urandom_range(0, 131071)) - 65536;
    endcase
  endfunction

  function automatic int pick_deadband();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 255 : 0;
    return int'($urandom_range(0, 12));
  endfunction

  function automatic int pick_zoom_limit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 65535 : 0;
      1: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic send_cmd(input int pan, input int tilt, input int zoom, input bit rel);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? int'($urandom_range(10, 40))
                                        : int'($urandom_range(1, 4));
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 60))
                                               : int'($urandom_range(1, 12));
    end
    burst_left--;
    in_tdata <= {7'd0, 17'(zoom), 12'(tilt), 12'(pan)};
    in_tuser <= rel;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off requests until every predicted byte is out, then let the
  // pipeline settle (requests with no frame may still be in flight)
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input int plo, input int phi, input int tlo, input int thi,
                              input int zlim, input int pdb, input int tdb, input int zdb);
    write_reg(REG_PAN_LO, {20'd0, 12'(plo)});
    write_reg(REG_PAN_HI, {20'd0, 12'(phi)});
    write_reg(REG_TILT_LO, {20'd0, 12'(tlo)});
    write_reg(REG_TILT_HI, {20'd0, 12'(thi)});
    write_reg(REG_ZOOM_LIM, {16'd0, 16'(zlim)});
    write_reg(REG_PAN_DB, {24'd0, 8'(pdb)});
    write_reg(REG_TILT_DB, {24'd0, 8'(tdb)});
    write_reg(REG_ZOOM_DB, {24'd0, 8'(zdb)});
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) wait_idle();
      send_cmd(pick_angle(), pick_angle(), pick_zoom(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_cmd(0, 0, 0, 1'b0);              // nothing moves
    send_cmd(10, 0, 0, 1'b0);             // pan only
    send_cmd(10, 20, 0, 1'b0);            // tilt only, pan resent
    send_cmd(10, 20, 500, 1'b0);          // zoom only
    send_cmd(11, 21, 501, 1'b0);          // inside dead bands
    send_cmd(2047, -2048, 65535, 1'b0);   // clamped both ways
    send_cmd(-2048, 2047, -65536, 1'b0);  // negative zoom target
    send_cmd(1, -1, 1, 1'b1);             // relative inside dead bands
    send_cmd(2, -2, 2, 1'b1);
    send_cmd(2047, 2047, 65535, 1'b1);    // relative sums past field range
    send_cmd(-2048, -2048, -65536, 1'b1);
    send_cmd(-1, -9, 3, 1'b0);            // negative angle rounding
    send_cmd(9, 1, 3, 1'b0);
    send_cmd(-5, 0, 0, 1'b0);
    send_cmd(0, 0, -100, 1'b1);           // relative zoom below zero
    send_cmd(0, 0, 1960, 1'b0);
    wait_idle();

    // widest limits, no dead band
    apply_config(-2048, 2047, -2048, 2047, 65535, 0, 0, 0);
    send_cmd(2047, 2047, 65535, 1'b0);
    send_cmd(2047, 2047, 65535, 1'b1);
    send_cmd(-2048, -2048, -65536, 1'b0);
    send_cmd(-2048, -2048, -65536, 1'b1);
    send_cmd(0, 0, 0, 1'b0);
    send_cmd(1, 0, 0, 1'b1);
    run_random(60);
    wait_idle();

    // crossed limits, widest dead bands
    apply_config(50, -50, 40, -40, 1960, 255, 255, 255);
    run_random(50);
    wait_idle();

    // crossed at the extremes, zoom pinned at zero
    apply_config(2047, -2048, 2047, -2048, 0, 0, 0, 0);
    run_random(50);
    wait_idle();

    repeat (4) begin
      apply_config(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                   pick_zoom_limit(), pick_deadband(), pick_deadband(), pick_deadband());
      run_random(50);
      wait_idle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ptzf_pkg.sv
hw/rtl/ptzf_front.sv
hw/rtl/ptzf_queue.sv
hw/rtl/ptzf_back.sv
hw/rtl/ptz_command_framer.sv
hw/rtl/ptzf_checker.sv
bench/ptzf_checker.sv
bench/tb_top.sv
